// ===== hdl/lkvc_pkg.sv =====
// Shared types and constants for the LRU key-value cache.
package lkvc_pkg;

	localparam int KEY_W = 16;
	localparam int VAL_W = 16;
	localparam int AGE_W = 32;
	localparam int CAP_CFG_W = 5;
	localparam int RES_W = 17;

	localparam logic CMD_GET = 1'b0;
	localparam logic CMD_PUT = 1'b1;

	localparam logic [CAP_CFG_W-1:0] CAP_RESET = 5'd16;
	localparam logic [RES_W-1:0] MISS_VALUE = 17'h1FFFF;

	typedef struct packed {
		logic             cmd;
		logic [KEY_W-1:0] key;
		logic             found;
		logic [VAL_W-1:0] rd_val;
		logic             match;
		logic [AGE_W-1:0] oldest_age;
	} lkvc_tok_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] val;
	} lkvc_wr_t;

endpackage

// ===== hdl/lkvc_cell.sv =====
// One cache entry cell: holds key, value and age, and processes the passing lookup token.
module lkvc_cell #(
	parameter int IDX = 0,
	parameter int IW  = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                filled,
	input  logic                tok_vld_in,
	input  lkvc_pkg::lkvc_tok_t tok_in,
	input  logic [IW-1:0]       midx_in,
	input  logic [IW-1:0]       oidx_in,
	output logic                tok_vld_out,
	output lkvc_pkg::lkvc_tok_t tok_out,
	output logic [IW-1:0]       midx_out,
	output logic [IW-1:0]       oidx_out,
	input  logic                wr_en,
	input  lkvc_pkg::lkvc_wr_t  wr
);
	import lkvc_pkg::*;

	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] val_q;
	logic [AGE_W-1:0] age_q;
	logic [AGE_W-1:0] age_inc;
	logic             hit;
	logic             active;
	lkvc_tok_t        tok_nx;
	logic [IW-1:0]    midx_nx;
	logic [IW-1:0]    oidx_nx;

	assign age_inc = (&age_q) ? age_q : age_q + AGE_W'(1);
	assign hit     = (key_q == tok_in.key);
	assign active  = tok_vld_in && filled;

	always_comb begin
		tok_nx  = tok_in;
		midx_nx = midx_in;
		oidx_nx = oidx_in;
		if (active) begin
			if (tok_in.cmd == CMD_GET) begin
				if (hit) begin
					tok_nx.found  = 1'b1;
					tok_nx.rd_val = val_q;
				end
			end else begin
				if (!tok_in.match && hit) begin
					tok_nx.match = 1'b1;
					midx_nx      = IW'(IDX);
				end
				if (age_inc > tok_in.oldest_age) begin
					tok_nx.oldest_age = age_inc;
					oidx_nx           = IW'(IDX);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_q <= wr.key;
			val_q <= wr.val;
			age_q <= '0;
		end else if (active) begin
			age_q <= (tok_in.cmd == CMD_GET && hit) ? '0 : age_inc;
		end
	end

	always_ff @(posedge clk) begin
		tok_out  <= tok_nx;
		midx_out <= midx_nx;
		oidx_out <= oidx_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_vld_out <= 1'b0;
		end else begin
			tok_vld_out <= tok_vld_in;
		end
	end

endmodule

// ===== hdl/lru_key_value_cache_top.sv =====
// Top level of the LRU key-value cache: request stream, cell chain and result register.
//
// Requests arrive on the s_ stream: tuser carries the command (get or put), tdata the
// key and the value. A get yields one transaction on the m_ stream: tdata holds the
// value found, or all ones in bits [16:0] on a miss; tuser holds the hit flag. A put
// yields nothing. Each accepted request launches a token that walks the row of
// CAPACITY entry cells, one cell per cycle; every filled cell compares its key, ages
// itself (a get hit resets its age) and updates the token's hit fields and, on a put,
// its oldest-entry fields. A put ends when its token leaves the last cell and the
// cache is updated; a get ends when its result is loaded into the output register,
// which raises m_tvalid. No new request is taken before then.
// One request is in flight at a time. The result register decouples the output:
// a new request is taken while a result still waits. If the receiver stalls and a
// second get result is ready, the block holds it and takes no request until the
// output register frees. capacity_in_use must be written through cfg_we/cfg_wdata
// only while idle; the block does not enforce this. Reset empties the cache, sets
// capacity_in_use to 16 and drops any pending result; no clearing pass is needed.
module lru_key_value_cache_top #(
	parameter int CAPACITY = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // key_in[15:0], value_in[31:16]
	input  logic [0:0]  s_tuser,   // cmd[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // read_value[16:0], zero[23:17]
	output logic [0:0]  m_tuser,   // hit[0]
	input  logic        cfg_we,
	input  logic [4:0]  cfg_wdata
);
	import lkvc_pkg::*;

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int UW = $clog2(CAPACITY + 1);
	localparam int CW = (UW > CAP_CFG_W) ? UW : CAP_CFG_W;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SWEEP = 3'b010,
		ST_OUT   = 3'b100
	} state_t;

	state_t               state_q;
	logic [CAP_CFG_W-1:0] cap_q;
	logic [UW-1:0]        used_q;
	logic [VAL_W-1:0]     put_val_q;
	logic                 res_found_q;
	logic [VAL_W-1:0]     res_val_q;
	logic                 m_tvalid_q;
	logic [RES_W-1:0]     m_data_q;
	logic                 m_hit_q;

	lkvc_tok_t            tok [CAPACITY+1];
	logic [CAPACITY:0]    tok_vld;
	logic [IW-1:0]        midx [CAPACITY+1];
	logic [IW-1:0]        oidx [CAPACITY+1];
	logic [CAPACITY-1:0]  filled;
	logic [CAPACITY-1:0]  wr_en;
	lkvc_wr_t             wr;

	logic                 accept;
	logic                 done;
	logic                 put_done;
	logic                 out_free;
	logic [CW-1:0]        cap_ext;
	logic [CW-1:0]        eff_cap;
	logic                 has_room;
	logic [IW-1:0]        target;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign done     = (state_q == ST_SWEEP) && tok_vld[CAPACITY];
	assign put_done = done && (tok[CAPACITY].cmd == CMD_PUT);
	assign out_free = !m_tvalid_q || m_tready;

	assign cap_ext  = CW'(cap_q);
	assign eff_cap  = (cap_ext == '0) ? CW'(1) :
	                  ((cap_ext > CW'(CAPACITY)) ? CW'(CAPACITY) : cap_ext);
	assign has_room = (CW'(used_q) < eff_cap);

	always_comb begin
		if (tok[CAPACITY].match) begin
			target = midx[CAPACITY];
		end else if (has_room) begin
			target = IW'(used_q);
		end else begin
			target = oidx[CAPACITY];
		end
	end

	assign wr.key = tok[CAPACITY].key;
	assign wr.val = put_val_q;

	// inject token at cell 0
	always_ff @(posedge clk) begin
		if (accept) begin
			tok[0].cmd        <= s_tuser[0];
			tok[0].key        <= s_tdata[15:0];
			tok[0].found      <= 1'b0;
			tok[0].rd_val     <= '0;
			tok[0].match      <= 1'b0;
			tok[0].oldest_age <= '0;
			midx[0]           <= '0;
			oidx[0]           <= '0;
			put_val_q         <= s_tdata[31:16];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_vld[0] <= 1'b0;
		end else begin
			tok_vld[0] <= accept;
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		assign filled[i] = (UW'(i) < used_q);
		assign wr_en[i]  = put_done && (target == IW'(i));

		lkvc_cell #(
			.IDX (i),
			.IW  (IW)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.filled      (filled[i]),
			.tok_vld_in  (tok_vld[i]),
			.tok_in      (tok[i]),
			.midx_in     (midx[i]),
			.oidx_in     (oidx[i]),
			.tok_vld_out (tok_vld[i+1]),
			.tok_out     (tok[i+1]),
			.midx_out    (midx[i+1]),
			.oidx_out    (oidx[i+1]),
			.wr_en       (wr_en[i]),
			.wr          (wr)
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			used_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SWEEP;
					end
				end
				ST_SWEEP: begin
					if (done) begin
						if (tok[CAPACITY].cmd == CMD_PUT) begin
							if (!tok[CAPACITY].match && has_room) begin
								used_q <= used_q + UW'(1);
							end
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			res_found_q <= tok[CAPACITY].found;
			res_val_q   <= tok[CAPACITY].rd_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			m_data_q <= res_found_q ? {1'b0, res_val_q} : MISS_VALUE;
			m_hit_q  <= res_found_q;
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = {7'd0, m_data_q};
	assign m_tuser[0] = m_hit_q;

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the LRU key-value cache: directed and random traffic against a predictor.
module tb_top;
	import lkvc_pkg::*;

	localparam int ENTRIES = 16;
	localparam int LATENCY = ENTRIES + 2;
	localparam int HOLD_START = 3000;
	localparam int HOLD_CYCLES = 400;
	localparam int CALM_START = 20000;
	localparam int CALM_END = 26000;
	localparam int POOL_DEPTH = 32;

	class cache_scoreboard;
		logic [KEY_W-1:0] keys [ENTRIES];
		logic [VAL_W-1:0] vals [ENTRIES];
		logic [AGE_W-1:0] ages [ENTRIES];
		int unsigned used;
		logic [CAP_CFG_W-1:0] capacity;
		logic [RES_W:0] lookups_due [$];
		int unsigned errors;

		function new();
			used = 0;
			capacity = CAP_RESET;
			errors = 0;
			foreach (keys[i]) begin
				keys[i] = '0;
				vals[i] = '0;
				ages[i] = '0;
			end
		endfunction

		function logic [AGE_W-1:0] aged(logic [AGE_W-1:0] a);
			return (a == '1) ? a : a + 1'b1;
		endfunction

		function int unsigned usable_entries();
			if (capacity == 0)
				return 1;
			if (capacity > ENTRIES)
				return ENTRIES;
			return capacity;
		endfunction

		function void set_capacity(logic [CAP_CFG_W-1:0] value);
			capacity = value;
		endfunction

		function int unsigned pending();
			return lookups_due.size();
		endfunction

		function void note_request(logic cmd, logic [KEY_W-1:0] key, logic [VAL_W-1:0] val);
			logic found;
			logic [VAL_W-1:0] got;
			logic match;
			int unsigned match_idx;
			int unsigned oldest_idx;
			int unsigned target;
			found = 1'b0;
			got = '0;
			match = 1'b0;
			match_idx = 0;
			oldest_idx = 0;
			if (cmd == CMD_GET) begin
				for (int unsigned i = 0; i < used; i++) begin
					if (keys[i] == key) begin
						found = 1'b1;
						got = vals[i];
						ages[i] = '0;
					end else begin
						ages[i] = aged(ages[i]);
					end
				end
				lookups_due.push_back({found, found ? {1'b0, got} : MISS_VALUE});
				return;
			end
			for (int unsigned i = 0; i < used; i++) begin
				ages[i] = aged(ages[i]);
				if (!match && keys[i] == key) begin
					match = 1'b1;
					match_idx = i;
				end
				if (ages[i] > ages[oldest_idx])
					oldest_idx = i;
			end
			if (match) begin
				target = match_idx;
			end else if (used < usable_entries()) begin
				target = used;
				used++;
			end else begin
				target = oldest_idx;
			end
			keys[target] = key;
			vals[target] = val;
			ages[target] = '0;
		endfunction

		function void check_result(logic [23:0] data, logic hit);
			logic [RES_W:0] want;
			if (lookups_due.size() == 0) begin
				$display("%0t: unexpected result: read_value %h hit %b", $time,
					data[RES_W-1:0], hit);
				errors++;
				return;
			end
			want = lookups_due.pop_front();
			if (data[RES_W-1:0] !== want[RES_W-1:0]) begin
				$display("%0t: read_value mismatch: expected %h, got %h", $time,
					want[RES_W-1:0], data[RES_W-1:0]);
				errors++;
			end
			if (hit !== want[RES_W]) begin
				$display("%0t: hit mismatch: expected %b, got %b", $time, want[RES_W], hit);
				errors++;
			end
			if (data[23:RES_W] !== '0) begin
				$display("%0t: tdata padding mismatch: expected %h, got %h", $time,
					7'h00, data[23:RES_W]);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [31:0] s_tdata = '0;
	logic [0:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic [0:0] m_tuser;
	logic cfg_we = 1'b0;
	logic [CAP_CFG_W-1:0] cfg_wdata = '0;

	logic sender_calm = 1'b0;
	logic [KEY_W-1:0] key_pool [POOL_DEPTH];
	cache_scoreboard sb = new();

	lru_key_value_cache_top #(
		.CAPACITY(ENTRIES)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			sb.note_request(s_tuser[0], s_tdata[KEY_W-1:0], s_tdata[31:KEY_W]);
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tuser[0]);
	end

	initial begin
		int unsigned cycle;
		cycle = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			cycle++;
			if (cycle >= HOLD_START && cycle < HOLD_START + HOLD_CYCLES)
				m_tready <= 1'b0;
			else if (cycle >= CALM_START && cycle < CALM_END)
				m_tready <= 1'b1;
			else
				m_tready <= ($urandom_range(99) >= 26);
		end
	end

	task automatic send_request(input logic cmd, input logic [KEY_W-1:0] key,
			input logic [VAL_W-1:0] val);
		while (!sender_calm && $urandom_range(99) < 26) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {val, key};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_CFG_W-1:0] value);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_capacity(value);
	endtask

	task automatic run_traffic(input logic [CAP_CFG_W-1:0] cap, input int count,
			input int pool, input logic calm);
		logic cmd;
		logic [KEY_W-1:0] key;
		write_capacity(cap);
		foreach (key_pool[i])
			key_pool[i] = KEY_W'($urandom);
		sender_calm = calm;
		for (int n = 0; n < count; n++) begin
			cmd = ($urandom_range(99) < 55) ? CMD_GET : CMD_PUT;
			key = ($urandom_range(9) == 0) ? KEY_W'($urandom) :
				key_pool[$urandom_range(pool - 1)];
			send_request(cmd, key, VAL_W'($urandom));
		end
		sender_calm = 1'b0;
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		write_capacity(5'd1);
		send_request(CMD_GET, 16'h0000, 16'h1357);
		send_request(CMD_PUT, 16'h0000, 16'hFFFF);
		send_request(CMD_GET, 16'h0000, 16'h0000);
		send_request(CMD_PUT, 16'hFFFF, 16'h0000);
		send_request(CMD_GET, 16'h0000, 16'hFFFF);
		send_request(CMD_GET, 16'hFFFF, 16'h0000);

		write_capacity(5'd0);
		send_request(CMD_PUT, 16'hA5A5, 16'h5A5A);
		send_request(CMD_GET, 16'hFFFF, 16'h0000);
		send_request(CMD_GET, 16'hA5A5, 16'h0000);

		write_capacity(5'd31);
		send_request(CMD_PUT, 16'h0001, 16'h0001);
		send_request(CMD_PUT, 16'h8000, 16'h8000);
		send_request(CMD_PUT, 16'hFFFF, 16'h7FFF);
		send_request(CMD_PUT, 16'h0001, 16'h1234);
		send_request(CMD_GET, 16'h0001, 16'h0000);
		send_request(CMD_GET, 16'h8000, 16'h0000);
		send_request(CMD_GET, 16'hFFFF, 16'h0000);
		send_request(CMD_GET, 16'hA5A5, 16'h0000);
		send_request(CMD_GET, 16'h1111, 16'h0000);
		send_request(CMD_PUT, 16'h8000, 16'hFFFF);
		send_request(CMD_GET, 16'h8000, 16'h0000);

		run_traffic(5'd16, 400, 24, 1'b1);
		run_traffic(5'd4, 250, 20, 1'b0);
		run_traffic(5'd1, 150, 3, 1'b0);
		run_traffic(5'd2, 150, 6, 1'b0);
		run_traffic(5'd0, 100, 3, 1'b0);
		run_traffic(5'd9, 300, 12, 1'b0);
		run_traffic(5'd31, 300, 20, 1'b0);
		run_traffic(5'd16, 200, 32, 1'b0);

		drain();
		repeat (LATENCY) @(posedge clk);
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/lkvc_pkg.sv
hdl/lkvc_cell.sv
hdl/lru_key_value_cache_top.sv
dv/tb_top.sv
